@@ hdl/qnpd_pkg.sv @@
// Shared types, constants and constellation tables for the QAM nearest point demapper.
// No dependencies; every other file of the block depends on this package.
package qnpd_pkg;

  // Default sample format.
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned FRAC_BITS    = 8;

  // Upper bound on the number of points one search visits.
  localparam int unsigned MAX_POINTS = 64;

  // Width of a point index and of the symbol bits.
  localparam int unsigned IDX_W = 6;

  // Width of one constellation coordinate (odd integers from -7 to 7).
  localparam int unsigned COORD_W = 4;

  // Points per mode after the point limit is applied.
  localparam int unsigned PtsQpsk  = (MAX_POINTS < 4)  ? MAX_POINTS : 4;
  localparam int unsigned PtsQam16 = (MAX_POINTS < 16) ? MAX_POINTS : 16;
  localparam int unsigned PtsQam64 = (MAX_POINTS < 64) ? MAX_POINTS : 64;

  // Modulation order codes held in the configuration register.
  typedef enum logic [1:0] {
    MODE_QPSK  = 2'd0,
    MODE_QAM16 = 2'd1,
    MODE_QAM64 = 2'd2
  } order_mode_e;

  // Search controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } ctrl_state_e;

  // Tag that travels with one point through the search pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } qnpd_tag_t;

  // Index of the last point searched in a mode.
  function automatic logic [IDX_W-1:0] last_index(order_mode_e mode);
    logic [IDX_W-1:0] res;
    unique case (mode)
      MODE_QPSK:  res = IDX_W'(PtsQpsk - 1);
      MODE_QAM16: res = IDX_W'(PtsQam16 - 1);
      MODE_QAM64: res = IDX_W'(PtsQam64 - 1);
      default:    res = IDX_W'(PtsQpsk - 1);
    endcase
    return res;
  endfunction

  // QPSK: bit 0 selects the real level, bit 1 the imaginary level.
  function automatic logic signed [COORD_W-1:0] qpsk_re(logic b);
    return b ? 4'sd1 : -4'sd1;
  endfunction

  function automatic logic signed [COORD_W-1:0] qpsk_im(logic b);
    return b ? -4'sd1 : 4'sd1;
  endfunction

  // 16-QAM: bits [3:2] give the real level, bits [1:0] the imaginary level.
  function automatic logic signed [COORD_W-1:0] qam16_re(logic [1:0] b);
    logic signed [COORD_W-1:0] res;
    unique case (b)
      2'd0:    res = -4'sd3;
      2'd1:    res = -4'sd1;
      2'd2:    res = 4'sd3;
      default: res = 4'sd1;
    endcase
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] qam16_im(logic [1:0] b);
    logic signed [COORD_W-1:0] res;
    unique case (b)
      2'd0:    res = 4'sd3;
      2'd1:    res = 4'sd1;
      2'd2:    res = -4'sd3;
      default: res = -4'sd1;
    endcase
    return res;
  endfunction

  // 64-QAM: both axes use the same Gray level map on three index bits.
  function automatic logic signed [COORD_W-1:0] qam64_level(logic [2:0] b);
    logic signed [COORD_W-1:0] res;
    unique case (b)
      3'd0:    res = -4'sd7;
      3'd1:    res = -4'sd5;
      3'd2:    res = -4'sd1;
      3'd3:    res = -4'sd3;
      3'd4:    res = 4'sd7;
      3'd5:    res = 4'sd5;
      3'd6:    res = 4'sd1;
      default: res = 4'sd3;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/qnpd_if.sv @@
// Valid/ready channel interfaces for sample input, symbol output and configuration.
// Depends on qnpd_pkg for the index width.
interface qnpd_in_if #(
  parameter int unsigned SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_i;
  logic signed [SW-1:0] sample_q;
  logic                 frame_end;

  modport source (output valid, sample_i, sample_q, frame_end, input ready);
  modport sink   (input valid, sample_i, sample_q, frame_end, output ready);
endinterface

interface qnpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [qnpd_pkg::IDX_W-1:0]   symbol_bits;
  logic                         frame_end_out;

  modport source (output valid, symbol_bits, frame_end_out, input ready);
  modport sink   (input valid, symbol_bits, frame_end_out, output ready);
endinterface

interface qnpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] order_mode;

  modport source (output valid, order_mode, input ready);
  modport sink   (input valid, order_mode, output ready);
endinterface

@@ hdl/qam_nearest_point_demapper.sv @@
// Hard-decision Gray QAM demapper: nearest constellation point by squared distance.
// The output beat is offered once all N points have been compared, N = 4, 16
// or 64 points per mode; one point is compared per cycle through the point store.
// Samples: a new sample is taken only after the last one's result has loaded; a stalled
// output only holds the next result back once its search has finished.
// Reset: clears the mode to QPSK, the sequencer to idle and the output to empty.
module qam_nearest_point_demapper
  import qnpd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = qnpd_pkg::SAMPLE_WIDTH,
  parameter int unsigned FRAC_BITS    = qnpd_pkg::FRAC_BITS,
  localparam int unsigned DW = ((SAMPLE_WIDTH > FRAC_BITS + 4) ?
                                SAMPLE_WIDTH : FRAC_BITS + 4) + 1
)(
  input logic          clk_i,
  input logic          rst_ni,
  qnpd_in_if.sink      in_i,
  qnpd_out_if.source   out_o,
  qnpd_cfg_if.sink     cfg_i
);

  order_mode_e               mode_q, mode_d;
  qnpd_tag_t                 issue, rom_tag, dist_tag;
  logic signed [COORD_W-1:0] re, im;
  logic signed [SAMPLE_WIDTH-1:0] si, sq;
  logic [2*DW-1:0]           a2, b2;

  // Mode register; a beat carrying the unused code leaves it unchanged.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.order_mode)
        MODE_QPSK, MODE_QAM16, MODE_QAM64: mode_d = order_mode_e'(cfg_i.order_mode);
        default:                           mode_d = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_QPSK;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Sequencer, running minimum and output register.
  qnpd_ctrl #(
    .SW (SAMPLE_WIDTH),
    .FB (FRAC_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .mode_i  (mode_q),
    .issue_o (issue),
    .si_o    (si),
    .sq_o    (sq),
    .a2_i    (a2),
    .b2_i    (b2),
    .tag_i   (dist_tag)
  );

  // Constellation point store.
  qnpd_point_rom u_rom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .tag_i  (issue),
    .re_o   (re),
    .im_o   (im),
    .tag_o  (rom_tag)
  );

  // Squared distance stage.
  qnpd_dist #(
    .SW (SAMPLE_WIDTH),
    .FB (FRAC_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .si_i   (si),
    .sq_i   (sq),
    .re_i   (re),
    .im_i   (im),
    .tag_i  (rom_tag),
    .a2_o   (a2),
    .b2_o   (b2),
    .tag_o  (dist_tag)
  );

endmodule

@@ hdl/qnpd_point_rom.sv @@
// Constellation point store with a registered read port, addressed by mode and index.
// Depends on qnpd_pkg for the Gray level maps and the pipeline tag type.
module qnpd_point_rom
  import qnpd_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  order_mode_e                      mode_i,
  input  qnpd_tag_t                        tag_i,
  output logic signed [COORD_W-1:0]        re_o,
  output logic signed [COORD_W-1:0]        im_o,
  output qnpd_tag_t                        tag_o
);

  logic signed [COORD_W-1:0] re_d, im_d;
  logic signed [COORD_W-1:0] re_q, im_q;
  qnpd_tag_t                 tag_q;

  // Table lookup for the addressed point.
  always_comb begin
    unique case (mode_i)
      MODE_QPSK: begin
        re_d = qpsk_re(tag_i.idx[0]);
        im_d = qpsk_im(tag_i.idx[1]);
      end
      MODE_QAM16: begin
        re_d = qam16_re(tag_i.idx[3:2]);
        im_d = qam16_im(tag_i.idx[1:0]);
      end
      MODE_QAM64: begin
        re_d = qam64_level(tag_i.idx[5:3]);
        im_d = qam64_level(tag_i.idx[2:0]);
      end
      default: begin
        re_d = qpsk_re(tag_i.idx[0]);
        im_d = qpsk_im(tag_i.idx[1]);
      end
    endcase
  end

  // Registered read data.
  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
  end

  // The tag marks which read data is live.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign re_o  = re_q;
  assign im_o  = im_q;
  assign tag_o = tag_q;

endmodule

@@ hdl/qnpd_dist.sv @@
// Squared axis distances between the held sample and one constellation point.
// Depends on qnpd_pkg; one multiplier per axis with a register behind each.
module qnpd_dist
  import qnpd_pkg::*;
#(
  parameter int unsigned SW = SAMPLE_WIDTH,
  parameter int unsigned FB = FRAC_BITS,
  localparam int unsigned DW = ((SW > FB + 4) ? SW : FB + 4) + 1
)(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [SW-1:0]      si_i,
  input  logic signed [SW-1:0]      sq_i,
  input  logic signed [COORD_W-1:0] re_i,
  input  logic signed [COORD_W-1:0] im_i,
  input  qnpd_tag_t                 tag_i,
  output logic [2*DW-1:0]           a2_o,
  output logic [2*DW-1:0]           b2_o,
  output qnpd_tag_t                 tag_o
);

  logic signed [DW-1:0] pre, pim, dre, dim;
  logic [DW-1:0]        are, aim;
  logic [2*DW-1:0]      a2_q, b2_q;
  qnpd_tag_t            tag_q;

  // Scale the point to the sample's fixed point and take absolute differences.
  always_comb begin
    pre = DW'(re_i) <<< FB;
    pim = DW'(im_i) <<< FB;
    dre = DW'(si_i) - pre;
    dim = DW'(sq_i) - pim;
    are = dre[DW-1] ? DW'(-dre) : DW'(dre);
    aim = dim[DW-1] ? DW'(-dim) : DW'(dim);
  end

  // Squares, registered before the sum.
  always_ff @(posedge clk_i) begin
    a2_q <= (2*DW)'(are) * (2*DW)'(are);
    b2_q <= (2*DW)'(aim) * (2*DW)'(aim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign a2_o  = a2_q;
  assign b2_o  = b2_q;
  assign tag_o = tag_q;

endmodule

@@ hdl/qnpd_ctrl.sv @@
// Search sequencer: takes a sample, walks the point indexes, keeps the nearest point
// and holds the result in an output register. Depends on qnpd_pkg and qnpd_if.
module qnpd_ctrl
  import qnpd_pkg::*;
#(
  parameter int unsigned SW = SAMPLE_WIDTH,
  parameter int unsigned FB = FRAC_BITS,
  localparam int unsigned DW    = ((SW > FB + 4) ? SW : FB + 4) + 1,
  localparam int unsigned DistW = 2 * DW + 1
)(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  qnpd_in_if.sink              in_i,
  qnpd_out_if.source           out_o,
  input  order_mode_e          mode_i,
  output qnpd_tag_t            issue_o,
  output logic signed [SW-1:0] si_o,
  output logic signed [SW-1:0] sq_o,
  input  logic [2*DW-1:0]      a2_i,
  input  logic [2*DW-1:0]      b2_i,
  input  qnpd_tag_t            tag_i
);

  ctrl_state_e          state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     last_idx_q;
  logic signed [SW-1:0] si_q, sq_q;
  logic                 fe_q;
  logic [DistW-1:0]     best_dist_q, dist_sum;
  logic [IDX_W-1:0]     best_idx_q;
  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_bits_q;
  logic                 out_fe_q;
  logic                 accept, load, at_last, take;

  assign accept  = in_i.valid && in_i.ready;
  assign at_last = (idx_q == last_idx_q);
  assign load    = (state_q == ST_HOLD) && (!out_valid_q || out_o.ready);

  // Next state and point issue.
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    in_i.ready    = 1'b0;
    issue_o.valid = 1'b0;
    issue_o.last  = at_last;
    issue_o.idx   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        idx_d      = '0;
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue_o.valid = 1'b1;
        idx_d         = idx_q + 1'b1;
        if (at_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag_i.valid && tag_i.last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Sample and search limit, captured with the input beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      si_q       <= in_i.sample_i;
      sq_q       <= in_i.sample_q;
      fe_q       <= in_i.frame_end;
      last_idx_q <= last_index(mode_i);
    end
  end

  assign si_o = si_q;
  assign sq_o = sq_q;

  // Distance sum and running minimum; the first point always seeds the minimum.
  assign dist_sum = DistW'(a2_i) + DistW'(b2_i);
  assign take     = tag_i.valid && ((tag_i.idx == '0) || (dist_sum < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q <= dist_sum;
      best_idx_q  <= tag_i.idx;
    end
  end

  // Output register, free to hold a result while the next sample is searched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_bits_q <= best_idx_q;
      out_fe_q   <= fe_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.symbol_bits   = out_bits_q;
  assign out_o.frame_end_out = out_fe_q;

endmodule
